@@ sv/rag_pkg.sv @@
`default_nettype none

package rag_pkg;

   // Default operand width; the result fields have fixed widths.
   localparam int OPERAND_BITS_DEF = 16;
   localparam int RESULT_NUM_BITS  = 32;
   localparam int RESULT_DEN_BITS  = 31;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_GCD_CHECK,
      ST_GCD_WAIT,
      ST_QNUM_GO,
      ST_QNUM_WAIT,
      ST_QDEN_GO,
      ST_QDEN_WAIT,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

@@ sv/rag_req_if.sv @@
`default_nettype none

interface rag_req_if
   import rag_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEF
);
   logic                           valid;
   logic                           ready;
   logic [1:0]                     mode;
   logic signed [OPERAND_BITS-1:0] left_num;
   logic signed [OPERAND_BITS-1:0] left_den;
   logic signed [OPERAND_BITS-1:0] right_num;
   logic signed [OPERAND_BITS-1:0] right_den;

   modport source (
      output valid, mode, left_num, left_den, right_num, right_den,
      input  ready
   );

   modport sink (
      input  valid, mode, left_num, left_den, right_num, right_den,
      output ready
   );
endinterface

`default_nettype wire

@@ sv/rag_rsp_if.sv @@
`default_nettype none

interface rag_rsp_if
   import rag_pkg::*;
();
   logic                              valid;
   logic                              ready;
   logic signed [RESULT_NUM_BITS-1:0] result_num;
   logic signed [RESULT_DEN_BITS-1:0] result_den;

   modport source (
      output valid, result_num, result_den,
      input  ready
   );

   modport sink (
      input  valid, result_num, result_den,
      output ready
   );
endinterface

`default_nettype wire

@@ sv/rag_div.sv @@
`default_nettype none

// Bit-serial signed divider with truncating quotient and a remainder that
// takes the sign of the dividend. One quotient bit is resolved per cycle.
module rag_div #(
   parameter int WIDTH = 34
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [WIDTH-1:0] dividend,
   input  wire logic signed [WIDTH-1:0] divisor,
   output logic                         done,
   output logic signed [WIDTH-1:0]      quotient,
   output logic signed [WIDTH-1:0]      remainder
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic             neg_q_ff, neg_r_ff;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] mag_b_ff;
   logic [WIDTH-1:0] mag_a;
   logic [WIDTH-1:0] mag_b;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;

   assign mag_a = dividend[WIDTH-1] ? WIDTH'(-dividend) : WIDTH'(dividend);
   assign mag_b = divisor[WIDTH-1]  ? WIDTH'(-divisor)  : WIDTH'(divisor);

   always_comb begin
      trial   = {rem_ff, quo_ff[WIDTH-1]};
      diff    = trial - {1'b0, mag_b_ff};
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CW'(WIDTH);
         quo_in = mag_a;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CW'(1);
         quo_in = {quo_ff[WIDTH-2:0], ~diff[WIDTH]};
         rem_in = diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         mag_b_ff <= mag_b;
         neg_q_ff <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
         neg_r_ff <= dividend[WIDTH-1];
      end
   end

   assign done      = done_ff;
   assign quotient  = neg_q_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign remainder = neg_r_ff ? -$signed(rem_ff) : $signed(rem_ff);

endmodule

`default_nettype wire

@@ sv/rational_arith_gcd_reduce.sv @@
`default_nettype none

// Channel   Direction  Contents
// req_ch    in         mode, left_num, left_den, right_num, right_den
// rsp_ch    out        result_num, result_den
//
// The bit-serial divider is shared by every Euclid remainder step and by
// the two final divisions.
// Reset is synchronous and active high; it returns the sequencer to idle and
// drops the result valid. A new request is taken as soon as the sequencer is
// idle, even while the previous result still waits in the output register;
// a stalled output only holds the sequencer in its last state.
module rational_arith_gcd_reduce
   import rag_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   rag_req_if.sink   req_ch,
   rag_rsp_if.source rsp_ch
);

   // Internal width: the cross-multiplied sum needs 2W+1 bits, and one more
   // keeps its magnitude representable inside the divider.
   localparam int W  = OPERAND_BITS;
   localparam int PW = 2 * OPERAND_BITS + 2;

   state_type state_ff, state_in;
   mode_type  op_ff;

   logic signed [W-1:0]  n1_ff, d1_ff, n2_ff, d2_ff;
   logic signed [PW-1:0] num_ff, p1_ff, den_ff;
   logic signed [PW-1:0] ga_ff, gb_ff;
   logic signed [PW-1:0] res_num_ff;

   logic signed [W-1:0]   mul_a, mul_b;
   logic signed [2*W-1:0] product;
   logic signed [PW-1:0]  product_ext;

   logic                 div_start;
   logic signed [PW-1:0] div_dividend, div_divisor;
   logic                 div_done;
   logic signed [PW-1:0] div_quo, div_rem;

   logic                              out_valid_ff;
   logic signed [RESULT_NUM_BITS-1:0] out_num_ff;
   logic signed [RESULT_DEN_BITS-1:0] out_den_ff;
   logic                              out_load;

   assign req_ch.ready = (state_ff == ST_IDLE);

   // The one shared multiplier; its product is registered in the multiply states.
   assign product     = mul_a * mul_b;
   assign product_ext = PW'(product);

   assign out_load = (state_ff == ST_OUT) && (!out_valid_ff || rsp_ch.ready);

   // Sequencer: next state plus the operand selection for the shared units.
   always_comb begin
      state_in     = state_ff;
      mul_a        = n1_ff;
      mul_b        = d2_ff;
      div_start    = 1'b0;
      div_dividend = ga_ff;
      div_divisor  = gb_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_MUL0;
         end
         ST_MUL0: begin
            // Multiply pairs the numerators; every other mode uses n1*d2.
            mul_a    = n1_ff;
            mul_b    = (op_ff == MODE_MUL) ? n2_ff : d2_ff;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            mul_a    = n2_ff;
            mul_b    = d1_ff;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            // Divide takes the right numerator into the denominator.
            mul_a    = d1_ff;
            mul_b    = (op_ff == MODE_DIV) ? n2_ff : d2_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_GCD_CHECK;
         end
         ST_GCD_CHECK: begin
            // Euclid ends when the running divisor reaches zero; the last
            // nonzero value, sign included, is the gcd.
            if (gb_ff == '0) begin
               state_in = ST_QNUM_GO;
            end else begin
               div_start = 1'b1;
               state_in  = ST_GCD_WAIT;
            end
         end
         ST_GCD_WAIT: begin
            if (div_done) state_in = ST_GCD_CHECK;
         end
         ST_QNUM_GO: begin
            div_start    = 1'b1;
            div_dividend = num_ff;
            div_divisor  = ga_ff;
            state_in     = ST_QNUM_WAIT;
         end
         ST_QNUM_WAIT: begin
            if (div_done) state_in = ST_QDEN_GO;
         end
         ST_QDEN_GO: begin
            div_start    = 1'b1;
            div_dividend = den_ff;
            div_divisor  = ga_ff;
            state_in     = ST_QDEN_WAIT;
         end
         ST_QDEN_WAIT: begin
            if (div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers, written according to the sequencer state.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               // A zero denominator on either operand counts as one.
               op_ff <= mode_type'(req_ch.mode);
               n1_ff <= req_ch.left_num;
               n2_ff <= req_ch.right_num;
               d1_ff <= (req_ch.left_den == '0) ? W'(1) : req_ch.left_den;
               d2_ff <= (req_ch.right_den == '0) ? W'(1) : req_ch.right_den;
            end
         end
         ST_MUL0: num_ff <= product_ext;
         ST_MUL1: p1_ff  <= product_ext;
         ST_MUL2: den_ff <= product_ext;
         ST_SUM: begin
            priority case (op_ff)
               MODE_ADD: begin
                  num_ff <= num_ff + p1_ff;
                  ga_ff  <= num_ff + p1_ff;
               end
               MODE_SUB: begin
                  num_ff <= num_ff - p1_ff;
                  ga_ff  <= num_ff - p1_ff;
               end
               default: begin
                  ga_ff <= num_ff;
               end
            endcase
            // A zero raw denominator (a divide by a zero-valued right operand)
            // becomes one.
            if (den_ff == '0) begin
               den_ff <= PW'(1);
               gb_ff  <= PW'(1);
            end else begin
               gb_ff <= den_ff;
            end
         end
         ST_GCD_WAIT: begin
            if (div_done) begin
               ga_ff <= gb_ff;
               gb_ff <= div_rem;
            end
         end
         ST_QNUM_WAIT: begin
            if (div_done) res_num_ff <= div_quo;
         end
         default: begin
         end
      endcase
   end

   // Output register: the denominator quotient is captured at the end of the
   // last division and held until the result can be loaded.
   logic signed [PW-1:0] res_den_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_QDEN_WAIT && div_done) res_den_ff <= div_quo;
      if (out_load) begin
         out_num_ff <= RESULT_NUM_BITS'(res_num_ff);
         out_den_ff <= RESULT_DEN_BITS'(res_den_ff);
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.result_num = out_num_ff;
   assign rsp_ch.result_den = out_den_ff;

   rag_div #(
      .WIDTH (PW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // The divider is never started with a zero divisor.
   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      div_start |-> (div_divisor != '0))
      else $error("divider started with a zero divisor");

   // A delivered result never carries a zero denominator.
   a_den_nonzero : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_den_ff != '0))
      else $error("result denominator is zero");

   // An accepted request always starts the multiply sequence.
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_MUL0))
      else $error("accepted request did not start the sequence");

endmodule

`default_nettype wire
